### hw/rtl/sha_sh_pkg.sv
`timescale 1ns / 1ps
package sha_sh_pkg;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  localparam logic [0:63][31:0] ROUND_K = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] INIT_H = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // controls for the byte packer and message schedule
  typedef struct packed {
    logic       byte_wr;
    logic [7:0] byte_val;
    logic [5:0] fill;
    logic       run;
    logic [6:0] step;
    logic [6:0] fetch;
  } sched_ctrl_t;

  // controls for the round unit and chaining value
  typedef struct packed {
    logic       load;
    logic       step;
    logic       fold;
    logic       reinit;
    logic [2:0] word_sel;
  } round_ctrl_t;

endpackage

### hw/rtl/sha_sh_ram.sv
`timescale 1ns / 1ps
module sha_sh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

### hw/rtl/sha_sh_sched.sv
`timescale 1ns / 1ps
module sha_sh_sched import sha_sh_pkg::*; (
  input  logic        clk,
  input  sched_ctrl_t ctrl,
  output logic [31:0] wk
);

  logic [23:0] word_buf;
  logic [31:0] hist1, hist2, w16;
  logic [31:0] rd_a, rd_b;
  logic [31:0] s0, s1, w_new;
  logic [3:0]  addr_a, addr_b, wr_addr;
  logic        wr_en;
  logic [31:0] wr_data;

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  // read for the next step: port a gives w[s-15], port b w[s] or w[s-7]
  always_comb begin
    addr_a = ctrl.fetch[3:0] + 4'd1;
    addr_b = (ctrl.fetch[6:4] == 3'b000) ? ctrl.fetch[3:0] : ctrl.fetch[3:0] + 4'd9;
  end

  always_comb begin
    s0    = small_sigma0(rd_a);
    s1    = small_sigma1(hist2);
    w_new = (ctrl.step[6:4] == 3'b000) ? rd_b : w16 + s0 + rd_b + s1;
  end

  // message bytes land a word at a time; schedule words overwrite w[s-16]
  always_comb begin
    if (ctrl.byte_wr) begin
      wr_en   = (ctrl.fill[1:0] == 2'b11);
      wr_addr = ctrl.fill[5:2];
      wr_data = {word_buf, ctrl.byte_val};
    end else begin
      wr_en   = ctrl.run && (ctrl.step[6:4] != 3'b000) && !ctrl.step[6];
      wr_addr = ctrl.step[3:0];
      wr_data = w_new;
    end
  end

  sha_sh_ram #(.WIDTH(32), .DEPTH(16)) u_words (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (addr_a),
    .rd_data_a (rd_a),
    .rd_addr_b (addr_b),
    .rd_data_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (ctrl.byte_wr) begin
      word_buf <= {word_buf[15:0], ctrl.byte_val};
    end
    if (ctrl.run) begin
      hist2 <= hist1;
      hist1 <= w_new;
      w16   <= rd_a;
      wk    <= w_new + ROUND_K[ctrl.step[5:0]];
    end
  end

endmodule

### hw/rtl/sha_sh_round.sv
`timescale 1ns / 1ps
module sha_sh_round import sha_sh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  round_ctrl_t ctrl,
  input  logic [31:0] wk,
  output logic [31:0] digest
);

  logic [0:7][31:0] chain;
  logic [0:7][31:0] v;
  logic [31:0] big0, big1, ch, maj, t1, t2;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  always_comb begin
    big0 = big_sigma0(v[0]);
    big1 = big_sigma1(v[4]);
    ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1   = v[7] + big1 + ch + wk;
    t2   = big0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= INIT_H;
      v     <= '0;
    end else begin
      if (ctrl.reinit) begin
        chain <= INIT_H;
      end else if (ctrl.fold) begin
        for (int j = 0; j < 8; j++) begin
          chain[j] <= chain[j] + v[j];
        end
      end
      if (ctrl.load) begin
        v <= chain;
      end else if (ctrl.step) begin
        v <= {t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
      end
    end
  end

  assign digest = chain[ctrl.word_sel];

endmodule

### hw/rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// sha-256 over a byte stream, one request per message byte
//
// input channel: data_byte with byte_present, end_of_message; in_valid/in_ready.
//   a request with byte_present 0 and end_of_message 0 is taken and ignored;
//   end_of_message with no byte closes the message, so an empty message works.
// output channel: digest_word, word_number, final_word; out_valid/out_ready.
//   eight requests per message, word 0 first, final_word on word 7.
// throughput: one byte per cycle while a block fills. the 64th byte of a block
//   starts a compression (chain load, schedule prime, 64 rounds on one round
//   unit, chain fold) during which in_ready is low.
// padding: after end_of_message the pad bytes go in one per cycle (64 minus the
//   fill, plus 64 when the length spills into an extra block), each block is
//   then compressed, and word 0 shows in the cycle after the last fold.
// the schedule memory has one write and two read ports; that pair of reads
//   sets the one-round-per-cycle pace.
// the receiver may stall for any time: a digest word holds until taken and no
//   input is taken before all eight words are out.
// reset: synchronous, active high; the chain value returns to the initial hash
//   and the byte count and block fill clear. the same happens after word 7.
module sha256_stream_hasher import sha_sh_pkg::*; #(
  parameter int COUNT_WIDTH = 61
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        final_word
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_PRIME = 7'b0000100,
    S_ROUND = 7'b0001000,
    S_FOLD  = 7'b0010000,
    S_PAD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                 state;
  logic [5:0]             fill;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [63:0]            len_sh;
  logic                   pad_active;
  logic                   sent80;
  logic                   len_arm;
  logic                   done;
  logic [5:0]             round_t;
  logic [2:0]             word_idx;

  logic        in_fire, out_fire;
  logic        put_en;
  logic [7:0]  put_val;
  sched_ctrl_t sctrl;
  round_ctrl_t rctrl;
  logic [31:0] wk;

  // handshakes
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign out_fire  = out_valid && out_ready;

  assign count_next = count + {{(COUNT_WIDTH-1){1'b0}}, byte_present};

  // byte source: message byte, or 0x80 then zeros then the bit length
  always_comb begin
    if (state == S_PAD) begin
      put_en = 1'b1;
      if (!sent80) begin
        put_val = PAD_BYTE;
      end else if (len_arm) begin
        put_val = len_sh[63:56];
      end else begin
        put_val = ZERO_BYTE;
      end
    end else begin
      put_en  = in_fire && byte_present;
      put_val = data_byte;
    end
  end

  // the schedule runs one step ahead of the rounds
  always_comb begin
    sctrl.byte_wr  = put_en;
    sctrl.byte_val = put_val;
    sctrl.fill     = fill;
    sctrl.run      = (state == S_PRIME) || (state == S_ROUND);
    sctrl.step     = (state == S_PRIME) ? 7'd0 : {1'b0, round_t} + 7'd1;
    if (state == S_LOAD) begin
      sctrl.fetch = 7'd0;
    end else if (state == S_PRIME) begin
      sctrl.fetch = 7'd1;
    end else begin
      sctrl.fetch = {1'b0, round_t} + 7'd2;
    end
  end

  always_comb begin
    rctrl.load     = (state == S_LOAD);
    rctrl.step     = (state == S_ROUND);
    rctrl.fold     = (state == S_FOLD);
    rctrl.reinit   = out_fire && (word_idx == 3'd7);
    rctrl.word_sel = word_idx;
  end

  sha_sh_sched u_sched (
    .clk  (clk),
    .ctrl (sctrl),
    .wk   (wk)
  );

  sha_sh_round u_round (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (rctrl),
    .wk     (wk),
    .digest (digest_word)
  );

  assign word_number = word_idx;
  assign final_word  = (word_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      count      <= '0;
      pad_active <= 1'b0;
      sent80     <= 1'b0;
      len_arm    <= 1'b0;
      done       <= 1'b0;
      round_t    <= '0;
      word_idx   <= '0;
    end else begin
      if (put_en) begin
        fill <= fill + 6'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            // the count restarts here; the length is latched in the same cycle
            count <= end_of_message ? '0 : count_next;
            if (end_of_message) begin
              len_sh     <= 64'(count_next) << 3;
              pad_active <= 1'b1;
              sent80     <= 1'b0;
              len_arm    <= 1'b0;
            end
            if (byte_present && (fill == 6'd63)) begin
              state <= S_LOAD;
            end else if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_LOAD: begin
          state <= S_PRIME;
        end
        S_PRIME: begin
          round_t <= '0;
          state   <= S_ROUND;
        end
        S_ROUND: begin
          round_t <= round_t + 6'd1;
          if (round_t == 6'd63) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (done) begin
            word_idx <= '0;
            state    <= S_OUT;
          end else if (pad_active) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          sent80 <= 1'b1;
          if (sent80 && len_arm) begin
            len_sh <= {len_sh[55:0], ZERO_BYTE};
          end
          // a pad byte in the last slot before the length arms it
          if (fill == 6'd55) begin
            len_arm <= 1'b1;
          end
          if (fill == 6'd63) begin
            state <= S_LOAD;
            if (len_arm) begin
              done       <= 1'b1;
              pad_active <= 1'b0;
              len_arm    <= 1'b0;
            end
          end
        end
        S_OUT: begin
          if (out_fire) begin
            word_idx <= word_idx + 3'd1;
            if (word_idx == 3'd7) begin
              done  <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a compression always starts on a block boundary
  a_load_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> (fill == 6'd0))
    else $error("compression started with a partial block");

  // the last round hands over to the chain fold
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    ((state == S_ROUND) && (round_t == 6'd63)) |=> (state == S_FOLD))
    else $error("round sequence did not end in fold");

  // the final fold opens the digest at word 0
  a_digest_start: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FOLD) && done) |=> (out_valid && (word_number == 3'd0)))
    else $error("digest did not start at word 0");

  // the length bytes follow the 0x80 marker
  a_len_order: assert property (@(posedge clk) disable iff (rst)
    len_arm |-> sent80)
    else $error("length armed before the pad marker");

  // after the last word the block is clear for a new message
  a_msg_clear: assert property (@(posedge clk) disable iff (rst)
    (out_fire && final_word) |=> (in_ready && (fill == 6'd0) && (count == '0)))
    else $error("state not cleared after digest");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;

  // run limits
  localparam int unsigned MAX_CYCLES  = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned TARGET_REQS = 230;
  // mid-digest, so the held words keep the input stalled
  localparam int unsigned HOLD_AFTER_WORDS = 60;
  localparam int unsigned MAX_SHOWN = 10;

  // padding bytes and block geometry
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] PAD_FILL = 8'h00;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_SLOT = 56;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // one pending request, with the gap that follows it
  typedef struct {
    logic [7:0]  dbyte;
    logic        present;
    logic        eom;
    int unsigned gap;
    bit          drain_first;
  } hash_req_t;

  // one expected digest word
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;

  hash_req_t   req_q[$];
  digest_exp_t digest_q[$];
  hash_req_t   next_req;
  digest_exp_t got_exp;

  // hash state kept alongside the block
  logic [31:0] chain_h [8];
  logic [7:0]  blk_buf [64];
  int unsigned blk_fill;
  logic [60:0] msg_len;

  // handshake bookkeeping
  logic        req_taken;
  logic        word_taken;
  int unsigned gap_left;
  int unsigned out_wait;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned words_seen;
  int unsigned cycle_cnt;
  int unsigned err_cnt;

  // stimulus bookkeeping
  bit          burst_mode;
  bit          drain_next;
  int unsigned req_cnt;
  int unsigned noise_cnt;
  int unsigned msg_cnt;
  int unsigned span_lens [6] = '{55, 56, 63, 64, 65, 120};

  sha256_stream_hasher u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_number    (word_number),
    .final_word     (final_word)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64-round compression of blk_buf into chain_h
  function automatic void sha_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, s0, s1, wt;
    int t;
    for (t = 0; t < 16; t++)
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        // rolling schedule, sixteen words deep
        s0 = rotr(w[(t-15) & 15], 7) ^ rotr(w[(t-15) & 15], 18) ^ (w[(t-15) & 15] >> 3);
        s1 = rotr(w[(t-2) & 15], 17) ^ rotr(w[(t-2) & 15], 19) ^ (w[(t-2) & 15] >> 10);
        wt = w[t & 15] + s0 + w[(t-7) & 15] + s1;
        w[t & 15] = wt;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + K_TAB[t] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  // one byte into the block, compressing when it fills
  function automatic void absorb(input logic [7:0] b);
    blk_buf[blk_fill] = b;
    blk_fill++;
    if (blk_fill == BLOCK_BYTES) begin
      sha_compress();
      blk_fill = 0;
    end
  endfunction

  // accepted request: take the byte, and on end of message pad and queue the digest
  function automatic void hash_request(input logic [7:0] b, input logic p, input logic e);
    logic [63:0] bit_cnt;
    digest_exp_t ex;
    int i;
    if (p) begin
      absorb(b);
      msg_len = msg_len + 61'd1;
    end
    if (e) begin
      bit_cnt = {3'b000, msg_len} << 3;
      absorb(PAD_MARK);
      while (blk_fill != LEN_SLOT)
        absorb(PAD_FILL);
      for (i = 0; i < 8; i++)
        absorb(bit_cnt[63 - 8*i -: 8]);
      for (i = 0; i < 8; i++) begin
        ex.word = chain_h[i];
        ex.idx  = 3'(i);
        ex.last = (i == 7);
        digest_q = {digest_q, ex};
      end
      chain_h  = H_INIT;
      blk_fill = 0;
      msg_len  = '0;
    end
  endfunction

  // per-request wait; half the time none, so zero-gap runs occur
  function automatic int unsigned draw_wait();
    return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic void add_item(input logic [7:0] b, input logic p, input logic e);
    hash_req_t it;
    it.dbyte       = b;
    it.present     = p;
    it.eom         = e;
    it.gap         = burst_mode ? 0 : draw_wait();
    it.drain_first = drain_next;
    drain_next     = 1'b0;
    req_q = {req_q, it};
    if (p || e)
      req_cnt++;
    else
      noise_cnt++;
    if (e)
      msg_cnt++;
  endfunction

  // random message of len bytes; close_last puts end_of_message on the last byte
  function automatic void add_message(input int unsigned len, input bit close_last);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      // sprinkle empty requests between bytes
      if ($urandom_range(0, 11) == 0)
        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_item(8'($urandom_range(0, 255)), 1'b1, close_last && (i == len - 1));
    end
    if (len == 0 || !close_last)
      add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endfunction

  // stimulus, reset and end of run
  initial begin
    int unsigned sel;
    int unsigned len_pick;
    rst            = 1'b1;
    in_valid       = 1'b0;
    data_byte      = '0;
    byte_present   = 1'b0;
    end_of_message = 1'b0;
    out_ready      = 1'b0;
    gap_left       = 0;
    out_wait       = 0;
    err_cnt        = 0;
    req_cnt        = 0;
    noise_cnt      = 0;
    msg_cnt        = 0;
    burst_mode     = 1'b0;
    drain_next     = 1'b0;
    chain_h        = H_INIT;
    blk_fill       = 0;
    msg_len        = '0;

    // directed: empty request, empty message, single bytes at the extremes,
    // "abc" closed on its last byte, back-to-back empty messages
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'hff, 1'b0, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(8'h5a, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    burst_mode = 1'b1;
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h63, 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hff, 1'b0, 1'b1);

    // random messages, mostly short, some right at the padding boundaries
    drain_next = 1'b1;
    while (req_cnt < TARGET_REQS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0)
        drain_next = 1'b1;
      sel = $urandom_range(0, 9);
      if (sel < 6)
        len_pick = $urandom_range(0, 20);
      else
        len_pick = span_lens[$urandom_range(0, 5)];
      // keep the request total near the target
      if (len_pick > TARGET_REQS - req_cnt)
        len_pick = TARGET_REQS - req_cnt;
      add_message(len_pick, $urandom_range(0, 1) != 0);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all requests taken, then all digests out, then a quiet tail
    while (req_q.size() != 0 || in_valid)
      @(posedge clk);
    while (digest_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("hashed %0d messages from %0d requests plus %0d empty requests",
             msg_cnt, req_cnt, noise_cnt);
    $display("checked %0d digest words, %0d mismatches, input stalled by a %0d-cycle hold",
             words_seen, err_cnt, HOLD_CYCLES);
    if (err_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // request driver: holds until taken, then waits out the gap of that request
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !req_taken) begin
        // request still waiting for in_ready
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() != 0 &&
                   !(req_q[0].drain_first && digest_q.size() != 0 && hold_left == 0)) begin
        // during the long hold the sender keeps offering
        next_req       = req_q.pop_front();
        data_byte      <= next_req.dbyte;
        byte_present   <= next_req.present;
        end_of_message <= next_req.eom;
        gap_left       <= next_req.gap;
        in_valid       <= 1'b1;
      end else begin
        // nothing to send, or pausing until every digest is out
        in_valid <= 1'b0;
      end
    end
  end

  // digest receiver ready: per-word wait, overridden by the long hold
  always @(negedge clk) begin : ready_gen
    int unsigned w;
    if (!rst) begin
      w = word_taken ? draw_wait() : out_wait;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        out_wait  <= w;
      end else if (w != 0) begin
        out_ready <= 1'b0;
        out_wait  <= w - 1;
      end else begin
        out_ready <= 1'b1;
        out_wait  <= 0;
      end
    end
  end

  // long receiver hold once a few messages are through, so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_seen >= HOLD_AFTER_WORDS) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check digest words, then fold accepted requests into the prediction
  always @(posedge clk) begin
    if (rst) begin
      req_taken  <= 1'b0;
      word_taken <= 1'b0;
      words_seen <= 0;
      cycle_cnt  <= 0;
    end else begin
      cycle_cnt  <= cycle_cnt + 1;
      req_taken  <= in_valid && in_ready;
      word_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        words_seen <= words_seen + 1;
        if (digest_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("unexpected digest word %0d: %h final %b",
                     word_number, digest_word, final_word);
        end else begin
          got_exp = digest_q.pop_front();
          if (digest_word !== got_exp.word || word_number !== got_exp.idx ||
              final_word !== got_exp.last) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN)
              $display("digest mismatch: expected word %0d %h final %b, got word %0d %h final %b",
                       got_exp.idx, got_exp.word, got_exp.last,
                       word_number, digest_word, final_word);
          end
        end
      end
      if (in_valid && in_ready)
        hash_request(data_byte, byte_present, end_of_message);
      if (cycle_cnt >= MAX_CYCLES) begin
        $display("timeout after %0d cycles, %0d digest words outstanding",
                 cycle_cnt, digest_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

### sha256_stream_hasher.f
hw/rtl/sha_sh_pkg.sv
hw/rtl/sha_sh_ram.sv
hw/rtl/sha_sh_sched.sv
hw/rtl/sha_sh_round.sv
hw/rtl/sha256_stream_hasher.sv
tb/tb.sv
